@@ hdl/kruskal_spanning_tree_macros.svh @@
// assertion macros for the spanning tree block
`ifndef KRUSKAL_SPANNING_TREE_MACROS_SVH
`define KRUSKAL_SPANNING_TREE_MACROS_SVH
// implication checked every clock outside reset
`define KST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define KST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ hdl/kst_pkg.sv @@
// ----------------------------------------------------------------------------
// kst_pkg
// types and constants shared by the spanning tree block
// ----------------------------------------------------------------------------
package kst_pkg;
    localparam int MaxVertices = 32;
    localparam int MaxEdges    = 256;
    localparam int WeightBits  = 16;
    localparam int VBits       = 5;
    localparam int EBits       = 8;
    localparam int FBits       = 9;

    typedef struct packed {
        logic                         edge_present;
        logic [VBits-1:0]             edge_src;
        logic [VBits-1:0]             edge_dst;
        logic signed [WeightBits-1:0] edge_weight;
        logic                         last_edge;
    } t_edge_in;

    typedef struct packed {
        logic                         tree_valid;
        logic [VBits-1:0]             tree_src;
        logic [VBits-1:0]             tree_dst;
        logic signed [WeightBits-1:0] tree_weight;
        logic                         run_end;
        logic                         spanning;
        logic                         overflowed;
    } t_tree_out;

    // one stored edge
    typedef struct packed {
        logic [VBits-1:0]             src;
        logic [VBits-1:0]             dst;
        logic signed [WeightBits-1:0] w;
    } t_edge;

    // control from the sequencer to the cell row
    typedef struct packed {
        logic             clear;   // reset forest
        logic             look;    // resolve roots of a/b
        logic             unite;   // merge looked-up roots, smaller set under larger
        logic [VBits-1:0] a;
        logic [VBits-1:0] b;
    } t_uf_ctl;

    typedef enum logic [2:0] {
        S_LOAD, S_SORT_RD, S_SORT_WR, S_SCAN_RD, S_FIND, S_DECIDE, S_EMIT
    } t_state;
endpackage

@@ hdl/kst_cell.sv @@
// ----------------------------------------------------------------------------
// kst_cell
// one vertex of the union-find forest; holds its root and its set size
// ----------------------------------------------------------------------------
module kst_cell import kst_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [VBits-1:0] i_index,
    input  t_uf_ctl          i_ctl,
    input  logic [VBits-1:0] i_root_a,
    input  logic [VBits-1:0] i_root_b,
    input  logic [VBits-1:0] i_root_in,
    output logic [VBits-1:0] o_root,
    output logic [VBits:0]   o_size
);
    logic [VBits-1:0] r_root, n_root;
    logic [VBits:0]   r_size, n_size;

    // each cell keeps its root directly (fully compressed forest);
    // i_root_in carries the size of the set being absorbed
    always_comb begin
        n_root = r_root;
        n_size = r_size;
        if (i_ctl.clear) begin
            n_root = i_index;
            n_size = (VBits+1)'(1);
        end else if (i_ctl.unite) begin
            if (r_root == i_root_b) n_root = i_root_a;
            if (i_index == i_root_a) n_size = r_size + {1'b0, i_root_in};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= i_index;
            r_size <= (VBits+1)'(1);
        end else begin
            r_root <= n_root;
            r_size <= n_size;
        end
    end

    assign o_root = r_root;
    assign o_size = r_size;
endmodule

@@ hdl/kst_forest.sv @@
// ----------------------------------------------------------------------------
// kst_forest
// row of vertex cells with root lookup and size-ordered join
// ----------------------------------------------------------------------------
module kst_forest import kst_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_uf_ctl          i_ctl,
    output logic             o_same
);
    logic [VBits-1:0] w_root [MaxVertices];
    logic [VBits:0]   w_size [MaxVertices];
    logic [VBits-1:0] r_ra, r_rb;
    logic [VBits-1:0] w_big, w_sml;
    logic [VBits-1:0] w_bsize;

    always_ff @(posedge i_clk) begin
        if (i_ctl.look) begin
            r_ra <= w_root[i_ctl.a];
            r_rb <= w_root[i_ctl.b];
        end
    end

    // larger set keeps its root; ties keep root of a
    always_comb begin
        if (w_size[r_ra] < w_size[r_rb]) begin
            w_big = r_rb;
            w_sml = r_ra;
        end else begin
            w_big = r_ra;
            w_sml = r_rb;
        end
        w_bsize = w_size[w_sml][VBits-1:0];
    end

    genvar g;
    generate
        for (g = 0; g < MaxVertices; g++) begin : g_cell
            kst_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_index  (VBits'(g)),
                .i_ctl    (i_ctl),
                .i_root_a (w_big),
                .i_root_b (w_sml),
                .i_root_in(w_bsize),
                .o_root   (w_root[g]),
                .o_size   (w_size[g])
            );
        end
    endgenerate

    assign o_same = (r_ra == r_rb);
endmodule

@@ hdl/kruskal_spanning_tree.sv @@
// ----------------------------------------------------------------------------
// kruskal_spanning_tree
// minimum spanning tree over a loaded edge list, one chosen edge per result
// ----------------------------------------------------------------------------
// usage
//   write i_cfg_we/i_cfg_data to set the vertex count while idle
//   raise start with an edge transaction; it is taken at an edge where busy is low
//   an accepted edge is insertion-sorted into the store: busy stays high while
//   heavier stored entries are shifted up one slot at a time;
//   an ignored or dropped edge that is not the last frees the input on the next cycle
//   on last_edge the store is scanned in weight order, each edge going through
//   store read, root lookup in the cell row, and decide and join, then the emit
//   state follows; the scan stops early once vertex_count-1 edges are chosen
//   a chosen edge is reported in the cycle after the next chosen edge is found;
//   the final result comes in the cycle after the emit state, as busy drops
//   chosen edges appear on o_result with o_result_valid for one cycle each
//   the last result carries run_end, spanning and overflowed
//   the receiver cannot stall; results are never held
//   reset clears control state and the forest; store contents need no clear
//   equal weights stay in arrival order
// ----------------------------------------------------------------------------
module kruskal_spanning_tree import kst_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [5:0] i_cfg_data,
    input  logic      start,
    output logic      busy,
    input  t_edge_in  i_item,
    output logic      o_result_valid,
    output t_tree_out o_result
);
    t_state r_state, n_state;
    logic [5:0]       r_vc;
    logic [FBits-1:0] r_fill, n_fill;
    logic [FBits-1:0] r_ptr, n_ptr;    // sort shift pointer / scan index
    logic [VBits-1:0] r_chosen, n_chosen;
    logic             r_drop, n_drop;
    logic             r_last, n_last;
    t_edge            r_new, n_new;     // edge being inserted
    t_edge            r_rd;             // registered store read
    t_edge            r_pend, n_pend;   // chosen edge awaiting output
    logic             r_have, n_have;
    logic             r_ov, n_ov;
    t_tree_out        r_res, n_res;
    logic             r_rv, n_rv;
    t_edge            r_mem [MaxEdges];
    logic [EBits-1:0] w_raddr;
    logic             w_we;
    logic [EBits-1:0] w_waddr;
    t_edge            w_wdata;
    t_uf_ctl          w_ctl;
    logic             w_same;
    logic [5:0]       w_vc;
    logic [5:0]       w_target;
    logic             w_acc;

    // effective count: zero acts as one, clamp to the cell row
    assign w_vc = (r_vc == 0) ? 6'd1 : ((r_vc > 6'(MaxVertices)) ? 6'(MaxVertices) : r_vc);
    assign w_target = w_vc - 6'd1;
    assign busy = (r_state != S_LOAD);
    assign w_acc = start && !busy;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rd <= r_mem[w_raddr];
    end

    kst_forest u_forest (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_ctl),
        .o_same (w_same)
    );

    always_comb begin
        n_state = r_state; n_fill = r_fill; n_ptr = r_ptr; n_chosen = r_chosen;
        n_drop = r_drop; n_last = r_last; n_new = r_new; n_pend = r_pend;
        n_have = r_have; n_ov = r_ov; n_res = r_res; n_rv = 1'b0;
        w_raddr = r_ptr[EBits-1:0] - EBits'(1);
        w_we = 1'b0; w_waddr = r_ptr[EBits-1:0]; w_wdata = r_rd;
        w_ctl = '0;
        unique case (r_state)
            S_LOAD: begin
                if (w_acc) begin
                    n_last = i_item.last_edge;
                    n_new = '{i_item.edge_src, i_item.edge_dst, i_item.edge_weight};
                    if (i_item.edge_present && 6'(i_item.edge_src) < w_vc
                        && 6'(i_item.edge_dst) < w_vc) begin
                        if (r_fill == FBits'(MaxEdges)) begin
                            n_drop = 1'b1;
                            n_state = i_item.last_edge ? S_SCAN_RD : S_LOAD;
                        end else begin
                            n_ptr = r_fill;
                            n_fill = r_fill + FBits'(1);
                            n_state = S_SORT_RD;
                        end
                    end else if (i_item.last_edge) begin
                        n_state = S_SCAN_RD;
                    end
                    if (n_state == S_SCAN_RD) begin
                        n_ptr = '0; n_ov = n_drop;
                    end
                end
            end
            S_SORT_RD: begin
                // read slot ptr-1, or place the edge if at the head
                if (r_ptr == 0) begin
                    w_we = 1'b1; w_wdata = r_new;
                    n_state = r_last ? S_SCAN_RD : S_LOAD;
                    if (r_last) begin n_ptr = '0; n_ov = r_drop; end
                end else begin
                    n_state = S_SORT_WR;
                end
            end
            S_SORT_WR: begin
                if (r_rd.w > r_new.w) begin
                    w_we = 1'b1; w_wdata = r_rd;
                    n_ptr = r_ptr - FBits'(1);
                    n_state = S_SORT_RD;
                end else begin
                    w_we = 1'b1; w_wdata = r_new;
                    n_state = r_last ? S_SCAN_RD : S_LOAD;
                    if (r_last) begin n_ptr = '0; n_ov = r_drop; end
                end
            end
            S_SCAN_RD: begin
                w_raddr = r_ptr[EBits-1:0];
                if (r_ptr == 0 && !r_have) w_ctl.clear = 1'b1;
                if (r_ptr >= r_fill || 6'(r_chosen) >= w_target) n_state = S_EMIT;
                else n_state = S_FIND;
            end
            S_FIND: begin
                // keep the scanned edge on the read port for the decide cycle
                w_raddr = r_ptr[EBits-1:0];
                w_ctl.look = 1'b1; w_ctl.a = r_rd.src; w_ctl.b = r_rd.dst;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_ptr = r_ptr + FBits'(1);
                n_state = S_SCAN_RD;
                if (6'(r_rd.src) < w_vc && 6'(r_rd.dst) < w_vc && !w_same) begin
                    w_ctl.unite = 1'b1;
                    n_chosen = r_chosen + VBits'(1);
                    if (r_have) begin
                        n_rv = 1'b1;
                        n_res = '{1'b1, r_pend.src, r_pend.dst, r_pend.w, 1'b0, 1'b0, 1'b0};
                    end
                    n_pend = r_rd; n_have = 1'b1;
                end
            end
            S_EMIT: begin
                n_rv = 1'b1;
                n_res = '{r_have, r_have ? r_pend.src : '0, r_have ? r_pend.dst : '0,
                          r_have ? r_pend.w : '0, 1'b1,
                          6'(r_chosen) == w_target, r_ov};
                n_fill = '0; n_chosen = '0; n_drop = 1'b0; n_have = 1'b0;
                n_state = S_LOAD;
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD; r_vc <= 6'd32; r_fill <= '0; r_chosen <= '0;
            r_drop <= 1'b0; r_have <= 1'b0; r_rv <= 1'b0; r_ptr <= '0;
            r_last <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_state <= n_state; r_fill <= n_fill; r_chosen <= n_chosen;
            r_drop <= n_drop; r_have <= n_have; r_rv <= n_rv; r_ptr <= n_ptr;
            r_last <= n_last; r_ov <= n_ov;
            if (i_cfg_we) r_vc <= i_cfg_data;
        end
        r_new <= n_new; r_pend <= n_pend; r_res <= n_res;
    end

    assign o_result_valid = r_rv;
    assign o_result = r_res;
endmodule

@@ hdl/kst_checker.sv @@
// ----------------------------------------------------------------------------
// kst_checker
// port-level checks for the spanning tree block
// ----------------------------------------------------------------------------
`include "kruskal_spanning_tree_macros.svh"
module kst_checker import kst_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input t_edge_in  i_item,
    input logic      o_result_valid,
    input t_tree_out o_result
);
    `KST_ASSERT_IMP(a_idle_quiet, i_clk, i_rst_n, !busy && !$past(busy), !o_result_valid)
    `KST_ASSERT_NXT(a_last_busy, i_clk, i_rst_n, start && !busy && i_item.last_edge, busy)
    `KST_ASSERT_NXT(a_end_free, i_clk, i_rst_n, o_result_valid && o_result.run_end, !o_result_valid)
    `KST_ASSERT_IMP(a_flags_end, i_clk, i_rst_n, o_result_valid && !o_result.run_end,
        o_result.tree_valid && !o_result.spanning && !o_result.overflowed)
endmodule

bind kruskal_spanning_tree kst_checker u_kst_checker (.*);
